// ===== hw/rtl/vpa_pkg.sv =====
// Shared types, constants and command codes for the variable partition allocator.
// Used by vpa_cell and variable_partition_allocator_top.
package vpa_pkg;

  localparam int MEM_BYTES        = 1024;
  localparam int HEADER_BYTES     = 8;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int ADDR_W           = 10;
  localparam int NEED_W           = ADDR_W + 1;

  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_SETFREE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] pay;
    logic              used;
  } entry_t;

  // start/pay: new tail block on insert; aux: remainder on insert, merged size on remove
  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] pay;
    logic [ADDR_W-1:0] aux;
  } cmd_t;

endpackage

// ===== hw/rtl/vpa_cell.sv =====
// One segment table entry; shifts with its neighbors on insert and remove.
// Depends on vpa_pkg.
module vpa_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  vpa_pkg::cmd_t   cmd,
  input  logic [IW-1:0]   cmd_pos,
  input  vpa_pkg::entry_t prev_in,
  input  vpa_pkg::entry_t next_in,
  output vpa_pkg::entry_t ent_out
);
  import vpa_pkg::*;

  entry_t ent_r, ent_nxt;

  always_comb begin
    int p;
    p = int'(cmd_pos);
    ent_nxt = ent_r;
    unique case (cmd.op)
      OP_INSERT: begin
        if (IDX > p + 1) begin
          ent_nxt = prev_in;
        end else if (IDX == p + 1) begin
          ent_nxt.start = cmd.start;
          ent_nxt.pay   = cmd.pay;
          ent_nxt.used  = 1'b1;
        end else if (IDX == p) begin
          ent_nxt.pay = cmd.aux;
        end
      end
      OP_REMOVE: begin
        if (IDX >= p) begin
          ent_nxt = next_in;
        end else if (IDX == p - 1) begin
          ent_nxt.pay = cmd.aux;
        end
      end
      OP_SETFREE: begin
        if (IDX == p) ent_nxt.used = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.start <= '0;
      ent_r.pay   <= (IDX == 0) ? ADDR_W'(MEM_BYTES - HEADER_BYTES) : '0;
      ent_r.used  <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_out = ent_r;

endmodule

// ===== hw/rtl/variable_partition_allocator_top.sv =====
// Variable partition allocator: top level with request sequencer and cell chain.
// Depends on vpa_pkg and vpa_cell.
//
// A request is taken when start is high and busy low. The segment table is a chain of
// cells scanned one entry per cycle through a single read port; an allocate scans, then
// inserts, and a free scans, then, once its block is found, merges with the next and then
// the previous neighbor. Requests rejected outright (zero size, full table) answer in the
// cycle after acceptance. Each request yields one result, shown for a single cycle with
// out_valid; the receiver cannot stall it.
module variable_partition_allocator_top #(
  parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic [vpa_pkg::ADDR_W-1:0] in_request_size,
  input  logic [vpa_pkg::ADDR_W-1:0] in_block_address,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [vpa_pkg::ADDR_W-1:0] out_granted_address,
  output logic [vpa_pkg::ADDR_W-1:0] out_released_size,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata
);
  import vpa_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_AINS  = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_FNEXT = 3'd4;
  localparam logic [2:0] S_FPREV = 3'd5;

  entry_t ent_arr [MAX_SEGMENTS];
  entry_t rd;
  cmd_t   cmd;
  logic [IW-1:0] cmd_pos, rd_idx;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        policy_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     rover_r, rover_nxt;
  logic [IW-1:0]     scan_r, scan_nxt, k_r, k_nxt;
  logic [IW-1:0]     pick_r, pick_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] pick_start_r, pick_start_nxt, pick_pay_r, pick_pay_nxt;
  logic [ADDR_W-1:0] size_r, size_nxt, addr_r, addr_nxt, cur_pay_r, cur_pay_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [ADDR_W-1:0] ogr_r, ogr_nxt, orel_r, orel_nxt;

  // cell chain
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    entry_t prv, nxt;
    if (g == 0) begin : g_first
      assign prv = '0;
    end else begin : g_mid
      assign prv = ent_arr[g-1];
    end
    if (g == MAX_SEGMENTS - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_inner
      assign nxt = ent_arr[g+1];
    end
    vpa_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_pos(cmd_pos),
      .prev_in(prv), .next_in(nxt), .ent_out(ent_arr[g])
    );
  end

  assign rd = ent_arr[rd_idx];

  always_comb begin
    logic [NEED_W-1:0] need;
    logic              fit, last, match;
    logic [CW-1:0]     adv, nidx;
    logic [NEED_W-1:0] tail;

    state_nxt      = state_r;
    count_nxt      = count_r;
    rover_nxt      = rover_r;
    scan_nxt       = scan_r;
    k_nxt          = k_r;
    pick_nxt       = pick_r;
    found_nxt      = found_r;
    pick_start_nxt = pick_start_r;
    pick_pay_nxt   = pick_pay_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    cur_pay_nxt    = cur_pay_r;
    ov_nxt         = 1'b0;
    ost_nxt        = ost_r;
    ogr_nxt        = ogr_r;
    orel_nxt       = orel_r;
    cmd            = '0;
    cmd_pos        = '0;
    rd_idx         = scan_r;

    need  = {1'b0, size_r} + NEED_W'(HEADER_BYTES);
    fit   = !rd.used && ({1'b0, rd.pay} >= need);
    match = rd.used && ({1'b0, rd.start} + NEED_W'(HEADER_BYTES) == {1'b0, addr_r});
    last  = (CW'(k_r) + CW'(1)) == count_r;
    adv   = CW'(scan_r) + CW'(1);
    if (policy_r == POL_NEXT && adv >= count_r) adv = '0;
    nidx  = CW'(pick_r) + CW'(1);
    tail  = {1'b0, pick_start_r} + {1'b0, pick_pay_r} - {1'b0, size_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          size_nxt  = in_request_size;
          addr_nxt  = in_block_address;
          k_nxt     = '0;
          found_nxt = 1'b0;
          if (in_kind == KIND_ALLOC) begin
            if (in_request_size == '0 || count_r >= CW'(MAX_SEGMENTS)) begin
              ov_nxt = 1'b1; ost_nxt = ST_NOFIT; ogr_nxt = '0; orel_nxt = '0;
            end else begin
              state_nxt = S_ASCAN;
              scan_nxt  = (policy_r == POL_NEXT && CW'(rover_r) < count_r) ? rover_r : '0;
            end
          end else begin
            state_nxt = S_FSCAN;
            scan_nxt  = '0;
          end
        end
      end
      S_ASCAN: begin
        k_nxt    = k_r + IW'(1);
        scan_nxt = IW'(adv);
        if (fit) begin
          priority case (policy_r)
            POL_BEST: begin
              if (!found_r || rd.pay <= pick_pay_r) begin
                found_nxt = 1'b1; pick_nxt = scan_r;
                pick_start_nxt = rd.start; pick_pay_nxt = rd.pay;
              end
            end
            POL_WORST: begin
              if (!found_r || rd.pay > pick_pay_r) begin
                found_nxt = 1'b1; pick_nxt = scan_r;
                pick_start_nxt = rd.start; pick_pay_nxt = rd.pay;
              end
            end
            default: begin
              found_nxt = 1'b1; pick_nxt = scan_r;
              pick_start_nxt = rd.start; pick_pay_nxt = rd.pay;
              state_nxt = S_AINS;
            end
          endcase
        end
        if (last) state_nxt = S_AINS;
      end
      S_AINS: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        orel_nxt  = '0;
        if (found_r) begin
          cmd.op    = OP_INSERT;
          cmd.start = ADDR_W'(tail);
          cmd.pay   = size_r;
          cmd.aux   = ADDR_W'({1'b0, pick_pay_r} - need);
          cmd_pos   = pick_r;
          count_nxt = count_r + CW'(1);
          rover_nxt = IW'(nidx);
          ost_nxt   = ST_DONE;
          ogr_nxt   = ADDR_W'(tail + NEED_W'(HEADER_BYTES));
        end else begin
          ost_nxt = ST_NOFIT;
          ogr_nxt = '0;
        end
      end
      S_FSCAN: begin
        k_nxt    = k_r + IW'(1);
        scan_nxt = scan_r + IW'(1);
        if (match) begin
          cmd.op      = OP_SETFREE;
          cmd_pos     = scan_r;
          pick_nxt    = scan_r;
          cur_pay_nxt = rd.pay;
          orel_nxt    = rd.pay;
          state_nxt   = S_FNEXT;
        end else if (last) begin
          state_nxt = S_IDLE;
          ov_nxt = 1'b1; ost_nxt = ST_UNKNOWN; ogr_nxt = '0; orel_nxt = '0;
        end
      end
      S_FNEXT: begin
        rd_idx    = IW'(nidx);
        state_nxt = S_FPREV;
        if (nidx < count_r && !rd.used) begin
          cmd.op      = OP_REMOVE;
          cmd_pos     = IW'(nidx);
          cmd.aux     = cur_pay_r + ADDR_W'(HEADER_BYTES) + rd.pay;
          cur_pay_nxt = cmd.aux;
          count_nxt   = count_r - CW'(1);
          if (CW'(rover_r) >= nidx && rover_r != '0) rover_nxt = rover_r - IW'(1);
        end
      end
      S_FPREV: begin
        rd_idx    = pick_r - IW'(1);
        state_nxt = S_IDLE;
        ov_nxt = 1'b1; ost_nxt = ST_DONE; ogr_nxt = '0;
        if (pick_r != '0 && !rd.used) begin
          cmd.op    = OP_REMOVE;
          cmd_pos   = pick_r;
          cmd.aux   = rd.pay + ADDR_W'(HEADER_BYTES) + cur_pay_r;
          count_nxt = count_r - CW'(1);
          if (rover_r >= pick_r && rover_r != '0) rover_nxt = rover_r - IW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      policy_r <= POL_FIRST;
      count_r  <= CW'(1);
      rover_r  <= '0;
      ov_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) policy_r <= cfg_wdata;
      count_r <= count_nxt;
      rover_r <= rover_nxt;
      ov_r    <= ov_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    k_r          <= k_nxt;
    pick_r       <= pick_nxt;
    pick_start_r <= pick_start_nxt;
    pick_pay_r   <= pick_pay_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    cur_pay_r    <= cur_pay_nxt;
    ost_r        <= ost_nxt;
    ogr_r        <= ogr_nxt;
    orel_r       <= orel_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_granted_address = ogr_r;
  assign out_released_size   = orel_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_cmd_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != OP_NOP |-> busy)
    else $error("table command while idle");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction dropped");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_NOFIT ||
                   out_status == ST_UNKNOWN))
    else $error("bad status code");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_INSERT |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow table");

endmodule

// ===== verif/tb_variable_partition_allocator_top.sv =====
// Self-checking testbench for variable_partition_allocator_top.
// Depends on vpa_pkg; an in-bench segment table model predicts each response.
module tb_variable_partition_allocator_top;
  import vpa_pkg::*;

  localparam int NSEG = MAX_SEGMENTS_DEF;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted;
    logic [ADDR_W-1:0] released;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic [ADDR_W-1:0] in_request_size = '0;
  logic [ADDR_W-1:0] in_block_address = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [ADDR_W-1:0] out_granted_address;
  logic [ADDR_W-1:0] out_released_size;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  variable_partition_allocator_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_request_size(in_request_size),
    .in_block_address(in_block_address), .out_valid(out_valid),
    .out_status(out_status), .out_granted_address(out_granted_address),
    .out_released_size(out_released_size), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state
  int unsigned seg_start [NSEG];
  int unsigned seg_pay [NSEG];
  bit seg_used [NSEG];
  int unsigned seg_cnt;
  int unsigned rover;
  logic [1:0] policy;

  resp_t pending_resp[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_grants = 0;
  int unsigned n_frees = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;

  function automatic void table_reset();
    for (int i = 0; i < NSEG; i++) begin
      seg_start[i] = 0;
      seg_pay[i] = 0;
      seg_used[i] = 0;
    end
    seg_pay[0] = MEM_BYTES - HEADER_BYTES;
    seg_cnt = 1;
    rover = 0;
    policy = POL_FIRST;
  endfunction

  function automatic void drop_merged(int unsigned j);
    for (int unsigned k = j; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_pay[k] = seg_pay[k+1];
      seg_used[k] = seg_used[k+1];
    end
    seg_cnt--;
    if (rover >= j && rover > 0) rover--;
  endfunction

  function automatic resp_t predict_alloc(int unsigned size);
    resp_t r;
    int unsigned need, pick, i, hole, room;
    r = '{ST_NOFIT, '0, '0};
    need = size + HEADER_BYTES;
    pick = NSEG;
    if (size == 0 || seg_cnt >= NSEG) return r;
    case (policy)
      POL_FIRST: begin
        for (i = 0; i < seg_cnt; i++)
          if (!seg_used[i] && seg_pay[i] >= need) begin
            pick = i;
            break;
          end
      end
      POL_BEST: begin
        for (i = 0; i < seg_cnt; i++)
          if (!seg_used[i] && seg_pay[i] >= need &&
              (pick == NSEG || seg_pay[i] <= seg_pay[pick])) pick = i;
      end
      POL_WORST: begin
        for (i = 0; i < seg_cnt; i++)
          if (!seg_used[i] && seg_pay[i] >= need &&
              (pick == NSEG || seg_pay[i] > seg_pay[pick])) pick = i;
      end
      default: begin
        i = (rover < seg_cnt) ? rover : 0;
        for (int unsigned k = 0; k < seg_cnt; k++) begin
          if (!seg_used[i] && seg_pay[i] >= need) begin
            pick = i;
            break;
          end
          i++;
          if (i >= seg_cnt) i = 0;
        end
      end
    endcase
    if (pick >= seg_cnt) return r;
    for (int unsigned k = seg_cnt; k > pick + 1; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_pay[k] = seg_pay[k-1];
      seg_used[k] = seg_used[k-1];
    end
    hole = seg_start[pick];
    room = seg_pay[pick];
    seg_pay[pick] = room - need;
    seg_start[pick+1] = hole + room - size;
    seg_pay[pick+1] = size;
    seg_used[pick+1] = 1'b1;
    seg_cnt++;
    rover = pick + 1;
    r.status = ST_DONE;
    r.granted = ADDR_W'(hole + room - size + HEADER_BYTES);
    return r;
  endfunction

  function automatic resp_t predict_free(int unsigned addr);
    resp_t r;
    int unsigned i;
    r = '{ST_UNKNOWN, '0, '0};
    for (i = 0; i < seg_cnt; i++)
      if (seg_used[i] && seg_start[i] + HEADER_BYTES == addr) break;
    if (i >= seg_cnt) return r;
    r.status = ST_DONE;
    r.released = ADDR_W'(seg_pay[i]);
    seg_used[i] = 1'b0;
    if (i + 1 < seg_cnt && !seg_used[i+1]) begin
      seg_pay[i] += HEADER_BYTES + seg_pay[i+1];
      drop_merged(i + 1);
    end
    if (i > 0 && !seg_used[i-1]) begin
      seg_pay[i-1] += HEADER_BYTES + seg_pay[i];
      drop_merged(i);
    end
    return r;
  endfunction

  // payload offset of a random used block, or a random address if none
  function automatic int unsigned pick_used_addr();
    int unsigned idx[$];
    for (int unsigned i = 0; i < seg_cnt; i++)
      if (seg_used[i]) idx.push_back(i);
    if (idx.size() == 0) return $urandom_range(1023, 0);
    return seg_start[idx[$urandom_range(idx.size() - 1, 0)]] + HEADER_BYTES;
  endfunction

  // sender gaps: bursts of random length, each in most cases preceded by a random pause
  task automatic sender_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3, 0) != 0) repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    burst_left--;
  endtask

  task automatic send_request(bit kind, int unsigned size, int unsigned addr, bit gaps = 1);
    resp_t r;
    if (gaps) sender_gap();
    start = 1'b1;
    in_kind = kind;
    in_request_size = ADDR_W'(size);
    in_block_address = ADDR_W'(addr);
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    r = (kind == KIND_ALLOC) ? predict_alloc(size & 1023) : predict_free(addr & 1023);
    pending_resp.push_back(r);
    n_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending_resp.size() != 0) @(negedge clk);
    // idle time before the next phase
    repeat (NSEG + 8) @(negedge clk);
  endtask

  task automatic write_policy(logic [1:0] p);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    policy = p;
  endtask

  task automatic free_all();
    int unsigned a;
    while (1) begin
      a = 0;
      for (int unsigned i = 0; i < seg_cnt; i++)
        if (seg_used[i]) begin
          a = seg_start[i] + HEADER_BYTES;
          break;
        end
      if (a == 0) break;
      send_request(1'b1, $urandom_range(1023, 0), a);
    end
  endtask

  task automatic test_directed();
    send_request(KIND_ALLOC, 0, 0);            // zero size
    send_request(KIND_ALLOC, 1023, 1023);      // too big
    send_request(KIND_ALLOC, MEM_BYTES - 2 * HEADER_BYTES, 0); // exactly fits
    send_request(1'b1, 1023, 0);               // unknown block
    send_request(1'b1, 0, HEADER_BYTES + 8);   // free exact block
    send_request(1'b1, 0, HEADER_BYTES + 8);   // double free
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_ALLOC, 512, 1023);
    free_all();
    // fill the table with small blocks until full
    for (int i = 0; i < NSEG + 1; i++) send_request(KIND_ALLOC, 8, 0);
    free_all();
  endtask

  task automatic test_policies();
    for (int p = 0; p < 4; p++) begin
      drain();
      write_policy(2'(p));
      // holes of varying size, then fits that separate the policies
      for (int i = 0; i < 8; i++) send_request(KIND_ALLOC, 16 + 8 * (i % 3), 0);
      for (int i = 0; i < 3; i++) send_request(1'b1, 0, pick_used_addr());
      for (int i = 0; i < 6; i++) send_request(KIND_ALLOC, $urandom_range(40, 1), 0);
      free_all();
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      write_policy(phase == 4 ? POL_NEXT : 2'($urandom_range(3, 0)));
      for (int i = 0; i < 70; i++) begin
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 50)
          send_request(KIND_ALLOC, $urandom_range(3, 0) == 0 ?
                       $urandom_range(1023, 0) : $urandom_range(64, 1),
                       $urandom_range(1023, 0));
        else if (sel < 90)
          send_request(1'b1, $urandom_range(1023, 0), pick_used_addr());
        else
          send_request(1'b1, $urandom_range(1023, 0), $urandom_range(1023, 0));
        if (i == 35) while (pending_resp.size() != 0) @(negedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    resp_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_variable_partition_allocator_top: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_resp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: status %0d", out_status);
      end else begin
        e = pending_resp.pop_front();
        n_checked++;
        if (e.status == ST_DONE && e.granted != 0) n_grants++;
        if (e.status == ST_DONE && e.released != 0) n_frees++;
        if (out_status !== e.status || out_granted_address !== e.granted ||
            out_released_size !== e.released) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp st=%0d ga=%0d rs=%0d got st=%0d ga=%0d rs=%0d",
                     n_checked, e.status, e.granted, e.released,
                     out_status, out_granted_address, out_released_size);
        end
      end
    end
  end

  initial begin
    table_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_policies();
    test_random();
    drain();
    errors += pending_resp.size();
    $display("transactions %0d sent, %0d checked; %0d grants, %0d releases over all policies",
             n_sent, n_checked, n_grants, n_frees);
    if (errors == 0)
      $display("tb_variable_partition_allocator_top: PASS");
    else
      $display("tb_variable_partition_allocator_top: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vpa_pkg.sv
hw/rtl/vpa_cell.sv
hw/rtl/variable_partition_allocator_top.sv
verif/tb_variable_partition_allocator_top.sv
